// ----- design/lcmlt_pkg.sv -----
package lcmlt_pkg;

    localparam int LEAF_COUNT_DEF = 1024;

    localparam logic signed [31:0] COORD_RESET = 32'sh4000_0000;
    localparam logic signed [62:0] NO_LINE     = 63'sh2000_0000_0000_0000;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADD_ALL = 2'd1;
    localparam logic [1:0] OP_ADD_SEG = 2'd2;
    localparam logic [1:0] OP_QUERY   = 2'd3;

    // one request walking down the row of level cells
    typedef struct packed {
        logic               valid;
        logic               query;
        logic               oob;
        logic signed [30:0] slope;
        logic signed [62:0] icpt;
        logic signed [31:0] x;
        logic signed [62:0] best;
    } t_req;

endpackage

// ----- design/li_chao_min_line_tree.sv -----
// Li Chao tree over a table of LEAF_COUNT sample x coordinates, giving the
// least value of the inserted lines at any table index. Each request carries
// an opcode: load a coordinate, add a line over the whole table, add a line
// over the index range [seg_left, seg_right), or query the minimum at
// point_index (the only request that returns a result). The tree is a row of
// level cells, root first, each holding its level's node lines and the
// first, middle and last coordinate of each node; every level works through
// a memory read, the multiplies, and a compare with write back. The input is
// stalled while an add or a query works its way down the row, and a range
// add first hands out its tree nodes one after another. One request is worked
// on at a time; up to two query results are held for the output side. After
// reset the block clears its memories, one entry at a time, and holds stall
// high meanwhile. Load coordinates before adding lines: the tree is not
// rebuilt on a late load.
module li_chao_min_line_tree #(
    parameter int LEAF_COUNT = lcmlt_pkg::LEAF_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_opcode,
    input  logic [9:0]          i_point_index,
    input  logic signed [30:0]  i_coord_value,
    input  logic signed [30:0]  i_slope,
    input  logic signed [60:0]  i_intercept,
    input  logic [10:0]         i_seg_left,
    input  logic [10:0]         i_seg_right,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [62:0]  o_min_value
);

    localparam int LOG_LEAF = $clog2(LEAF_COUNT);
    localparam int LVW      = $clog2(LOG_LEAF + 1);

    lcmlt_pkg::t_req     inj;
    logic [LVW-1:0]      inj_lvl;
    logic [LOG_LEAF-1:0] inj_path;
    logic                clr;
    logic [LOG_LEAF-1:0] clr_addr;
    logic                ld;
    logic [LOG_LEAF-1:0] ld_idx;
    logic signed [31:0]  ld_val;
    logic                room;
    logic                chain_busy;

    lcmlt_pkg::t_req     w_req  [LOG_LEAF+1];
    logic [LOG_LEAF-1:0] w_path [LOG_LEAF+1];
    logic [LOG_LEAF:0]   w_busy;

    logic [1:0]          r_ocnt;
    logic signed [62:0]  r_q0, r_q1;
    logic                push, pop, accept;

    lcmlt_ctrl #(.LOG_LEAF(LOG_LEAF)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_coord_value (i_coord_value),
        .i_slope       (i_slope),
        .i_intercept   (i_intercept),
        .i_seg_left    (i_seg_left),
        .i_seg_right   (i_seg_right),
        .i_room        (room),
        .i_chain_busy  (chain_busy),
        .o_stall       (o_stall),
        .o_inj         (inj),
        .o_inj_lvl     (inj_lvl),
        .o_inj_path    (inj_path),
        .o_clr         (clr),
        .o_clr_addr    (clr_addr),
        .o_ld          (ld),
        .o_ld_idx      (ld_idx),
        .o_ld_val      (ld_val)
    );

    // one cell per tree level, root at level 0, leaves last
    for (genvar k = 0; k <= LOG_LEAF; k++) begin : g_cell
        lcmlt_pkg::t_req     c_prev;
        logic [LOG_LEAF-1:0] c_prev_path;
        if (k == 0) begin : g_head
            assign c_prev      = '0;
            assign c_prev_path = '0;
        end else begin : g_link
            assign c_prev      = w_req[k-1];
            assign c_prev_path = w_path[k-1];
        end
        lcmlt_cell #(.LOG_LEAF(LOG_LEAF), .LVL(k)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_prev      (c_prev),
            .i_prev_path (c_prev_path),
            .i_inj       (inj),
            .i_inj_lvl   (inj_lvl),
            .i_inj_path  (inj_path),
            .i_clr       (clr),
            .i_clr_addr  (clr_addr),
            .i_ld        (ld),
            .i_ld_idx    (ld_idx),
            .i_ld_val    (ld_val),
            .o_req       (w_req[k]),
            .o_path      (w_path[k]),
            .o_busy      (w_busy[k])
        );
    end

    assign chain_busy = |w_busy;

    // a query leaving the leaf cell carries its minimum; insertions drop here
    assign push    = w_req[LOG_LEAF].valid && w_req[LOG_LEAF].query;
    assign pop     = o_valid && !i_stall;
    assign accept  = i_valid && !o_stall;
    assign room    = !r_ocnt[1];
    assign o_valid = r_ocnt != 2'd0;
    assign o_min_value = r_q0;

    // two-entry result buffer, head in r_q0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= 2'd0;
        end else begin
            r_ocnt <= r_ocnt + 2'(push) - 2'(pop);
        end
        if (pop) begin
            r_q0 <= r_q1;
        end
        if (push) begin
            if (r_ocnt - 2'(pop) == 2'd0) begin
                r_q0 <= w_req[LOG_LEAF].best;
            end else begin
                r_q1 <= w_req[LOG_LEAF].best;
            end
        end
    end

    a_ocnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt != 2'd3)
        else $error("result buffer count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_ocnt != 2'd2 || pop))
        else $error("result arrived with a full buffer");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !chain_busy)
        else $error("request accepted while the cell row is busy");

endmodule

// ----- design/lcmlt_cell.sv -----
module lcmlt_cell #(
    parameter int LOG_LEAF = 10,
    parameter int LVL      = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcmlt_pkg::t_req                 i_prev,
    input  logic [LOG_LEAF-1:0]             i_prev_path,
    input  lcmlt_pkg::t_req                 i_inj,
    input  logic [$clog2(LOG_LEAF+1)-1:0]   i_inj_lvl,
    input  logic [LOG_LEAF-1:0]             i_inj_path,
    input  logic                            i_clr,
    input  logic [LOG_LEAF-1:0]             i_clr_addr,
    input  logic                            i_ld,
    input  logic [LOG_LEAF-1:0]             i_ld_idx,
    input  logic signed [31:0]              i_ld_val,
    output lcmlt_pkg::t_req                 o_req,
    output logic [LOG_LEAF-1:0]             o_path,
    output logic                            o_busy
);

    localparam int LVW   = $clog2(LOG_LEAF + 1);
    localparam int SH    = LOG_LEAF - LVL;
    localparam int LW    = (LVL == 0) ? 1 : LVL;
    localparam int DEPTH = 1 << LW;
    localparam int CB    = (SH > 0) ? SH - 1 : 0;
    localparam logic [LOG_LEAF-1:0] OFF_MASK = LOG_LEAF'((1 << SH) - 1);
    localparam logic [LOG_LEAF-1:0] HALF     = LOG_LEAF'((1 << SH) >> 1);

    logic signed [30:0] m_slope [DEPTH];
    logic signed [62:0] m_icpt  [DEPTH];
    logic signed [31:0] m_xl    [DEPTH];
    logic signed [31:0] m_xm    [DEPTH];
    logic signed [31:0] m_xr    [DEPTH];

    lcmlt_pkg::t_req     s_req;
    logic [LOG_LEAF-1:0] s_path;
    logic [LW-1:0]       s_addr;
    logic [LW-1:0]       ld_addr;
    logic [LW-1:0]       clr_addr;
    logic [LOG_LEAF-1:0] ld_off;

    lcmlt_pkg::t_req     r_a_req;
    logic [LOG_LEAF-1:0] r_a_path;
    logic [LW-1:0]       r_a_addr;
    logic signed [30:0]  r_m_slope;
    logic signed [62:0]  r_m_icpt;
    logic signed [31:0]  r_m_xl, r_m_xm, r_m_xr;

    logic signed [31:0]  b_xl;
    lcmlt_pkg::t_req     r_b_req;
    logic [LOG_LEAF-1:0] r_b_path;
    logic [LW-1:0]       r_b_addr;
    logic signed [30:0]  r_b_sa;
    logic signed [62:0]  r_b_sb;
    logic signed [62:0]  r_pnl, r_pnm, r_pnr, r_psl, r_psm, r_psr;

    logic signed [63:0]  vnl, vnm, vnr, vsl, vsm, vsr;
    logic                c_ld, c_md, c_rd;
    logic                c_wr;
    lcmlt_pkg::t_req     n_o_req;
    logic [LOG_LEAF-1:0] n_o_path;
    lcmlt_pkg::t_req     r_o_req;
    logic [LOG_LEAF-1:0] r_o_path;

    always_comb begin
        if (i_inj.valid && i_inj_lvl == LVW'(LVL)) begin
            s_req  = i_inj;
            s_path = i_inj_path;
        end else begin
            s_req  = i_prev;
            s_path = i_prev_path;
        end
    end

    assign s_addr   = LW'(s_path >> SH);
    assign ld_addr  = LW'(i_ld_idx >> SH);
    assign clr_addr = i_clr_addr[LW-1:0];
    assign ld_off   = i_ld_idx & OFF_MASK;

    // node and coordinate storage of this level
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            m_slope[clr_addr] <= '0;
            m_icpt[clr_addr]  <= lcmlt_pkg::NO_LINE;
            m_xl[clr_addr]    <= lcmlt_pkg::COORD_RESET;
            m_xm[clr_addr]    <= lcmlt_pkg::COORD_RESET;
            m_xr[clr_addr]    <= lcmlt_pkg::COORD_RESET;
        end else begin
            if (c_wr) begin
                m_slope[r_b_addr] <= r_b_req.slope;
                m_icpt[r_b_addr]  <= r_b_req.icpt;
            end
            if (i_ld) begin
                if (ld_off == '0) begin
                    m_xl[ld_addr] <= i_ld_val;
                end
                if (ld_off == HALF) begin
                    m_xm[ld_addr] <= i_ld_val;
                end
                if (ld_off == OFF_MASK) begin
                    m_xr[ld_addr] <= i_ld_val;
                end
            end
        end
        r_m_slope <= m_slope[s_addr];
        r_m_icpt  <= m_icpt[s_addr];
        r_m_xl    <= m_xl[s_addr];
        r_m_xm    <= m_xm[s_addr];
        r_m_xr    <= m_xr[s_addr];
    end

    assign b_xl = r_a_req.query ? r_a_req.x : r_m_xl;

    assign vnl = r_pnl + r_b_req.icpt;
    assign vnm = r_pnm + r_b_req.icpt;
    assign vnr = r_pnr + r_b_req.icpt;
    assign vsl = r_psl + r_b_sb;
    assign vsm = r_psm + r_b_sb;
    assign vsr = r_psr + r_b_sb;
    assign c_ld = vnl < vsl;
    assign c_md = vnm < vsm;
    assign c_rd = vnr < vsr;

    always_comb begin
        n_o_req  = r_b_req;
        n_o_path = r_b_path;
        c_wr     = 1'b0;
        if (r_b_req.valid) begin
            if (r_b_req.query) begin
                if (!r_b_req.oob && vsl < 64'(r_b_req.best)) begin
                    n_o_req.best = vsl[62:0];
                end
            end else if (!c_ld && !c_rd) begin
                n_o_req.valid = 1'b0;
            end else if (c_ld && c_rd) begin
                c_wr          = 1'b1;
                n_o_req.valid = 1'b0;
            end else begin
                if (c_md) begin
                    c_wr          = 1'b1;
                    n_o_req.slope = r_b_sa;
                    n_o_req.icpt  = r_b_sb;
                end
                if (SH > 0 && c_ld == c_md) begin
                    n_o_path[CB] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_req.valid <= 1'b0;
            r_b_req.valid <= 1'b0;
            r_o_req.valid <= 1'b0;
        end else begin
            r_a_req  <= s_req;
            r_a_path <= s_path;
            r_a_addr <= s_addr;
            r_b_req  <= r_a_req;
            r_b_path <= r_a_path;
            r_b_addr <= r_a_addr;
            r_b_sa   <= r_m_slope;
            r_b_sb   <= r_m_icpt;
            r_pnl    <= r_a_req.slope * b_xl;
            r_pnm    <= r_a_req.slope * r_m_xm;
            r_pnr    <= r_a_req.slope * r_m_xr;
            r_psl    <= r_m_slope * b_xl;
            r_psm    <= r_m_slope * r_m_xm;
            r_psr    <= r_m_slope * r_m_xr;
            r_o_req  <= n_o_req;
            r_o_path <= n_o_path;
        end
    end

    assign o_req  = r_o_req;
    assign o_path = r_o_path;
    assign o_busy = r_a_req.valid | r_b_req.valid | r_o_req.valid;

endmodule

// ----- design/lcmlt_ctrl.sv -----
module lcmlt_ctrl #(
    parameter int LOG_LEAF = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [1:0]                      i_opcode,
    input  logic [9:0]                      i_point_index,
    input  logic signed [30:0]              i_coord_value,
    input  logic signed [30:0]              i_slope,
    input  logic signed [60:0]              i_intercept,
    input  logic [10:0]                     i_seg_left,
    input  logic [10:0]                     i_seg_right,
    input  logic                            i_room,
    input  logic                            i_chain_busy,
    output logic                            o_stall,
    output lcmlt_pkg::t_req                 o_inj,
    output logic [$clog2(LOG_LEAF+1)-1:0]   o_inj_lvl,
    output logic [LOG_LEAF-1:0]             o_inj_path,
    output logic                            o_clr,
    output logic [LOG_LEAF-1:0]             o_clr_addr,
    output logic                            o_ld,
    output logic [LOG_LEAF-1:0]             o_ld_idx,
    output logic signed [31:0]              o_ld_val
);

    localparam int LEAF = 1 << LOG_LEAF;
    localparam int LVW  = $clog2(LOG_LEAF + 1);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_QRD, ST_SEGL, ST_SEGR, ST_DRAIN
    } t_state;

    t_state              r_state;
    logic [LOG_LEAF-1:0] r_cnt;
    lcmlt_pkg::t_req     r_inj;
    logic [LVW-1:0]      r_inj_lvl;
    logic [LOG_LEAF-1:0] r_inj_path;
    logic                r_ld;
    logic [LOG_LEAF-1:0] r_ld_idx;
    logic signed [31:0]  r_ld_val;
    logic [LOG_LEAF-1:0] r_qidx;
    logic                r_oob;
    logic signed [30:0]  r_slope;
    logic signed [62:0]  r_icpt;
    logic [LOG_LEAF:0]   r_l, r_r, r_sz;
    logic [LOG_LEAF+1:0] r_nl, r_nr;
    logic [LVW-1:0]      r_lvl;

    logic signed [31:0]  m_coord [LEAF];
    logic signed [31:0]  r_qx;

    logic                accept, in_range;
    logic [LOG_LEAF-1:0] p_addr;
    logic [31:0]         l_w, r_w, l_s, r_s;
    logic [LOG_LEAF:0]   r_lo;
    logic [LOG_LEAF+1:0] nr_dec;

    assign accept   = i_valid && r_state == ST_IDLE && i_room;
    assign o_stall  = !(r_state == ST_IDLE && i_room);
    assign in_range = 32'(i_point_index) < 32'(LEAF);
    assign p_addr   = LOG_LEAF'(i_point_index);
    assign l_w      = 32'(i_seg_left);
    assign r_w      = 32'(i_seg_right);
    assign l_s      = (l_w > 32'(LEAF)) ? 32'(LEAF) : l_w;
    assign r_s      = (r_w > 32'(LEAF)) ? 32'(LEAF) : r_w;
    assign r_lo     = r_r - r_sz;
    assign nr_dec   = r_nr[0] ? r_nr - (LOG_LEAF+2)'(1) : r_nr;

    // coordinate copy used to start a query
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            m_coord[r_cnt] <= lcmlt_pkg::COORD_RESET;
        end else if (accept && i_opcode == lcmlt_pkg::OP_LOAD && in_range) begin
            m_coord[p_addr] <= 32'(i_coord_value);
        end
        r_qx <= m_coord[p_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_inj.valid <= 1'b0;
            r_ld      <= 1'b0;
        end else begin
            r_inj.valid <= 1'b0;
            r_ld        <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + LOG_LEAF'(1);
                    if (&r_cnt) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_slope <= i_slope;
                        r_icpt  <= 63'(i_intercept);
                        unique case (i_opcode)
                            lcmlt_pkg::OP_LOAD: begin
                                r_ld     <= in_range;
                                r_ld_idx <= p_addr;
                                r_ld_val <= 32'(i_coord_value);
                            end
                            lcmlt_pkg::OP_ADD_ALL: begin
                                r_inj <= '{valid: 1'b1, query: 1'b0, oob: 1'b0,
                                           slope: i_slope, icpt: 63'(i_intercept),
                                           x: '0, best: lcmlt_pkg::NO_LINE};
                                r_inj_lvl  <= '0;
                                r_inj_path <= '0;
                                r_state    <= ST_DRAIN;
                            end
                            lcmlt_pkg::OP_ADD_SEG: begin
                                r_l     <= (LOG_LEAF+1)'(l_s);
                                r_r     <= (LOG_LEAF+1)'(r_s);
                                r_nl    <= (LOG_LEAF+2)'(32'(LEAF) + l_s);
                                r_nr    <= (LOG_LEAF+2)'(32'(LEAF) + r_s);
                                r_sz    <= (LOG_LEAF+1)'(1);
                                r_lvl   <= LVW'(LOG_LEAF);
                                if (l_s < r_s) begin
                                    r_state <= ST_SEGL;
                                end
                            end
                            lcmlt_pkg::OP_QUERY: begin
                                r_qidx  <= p_addr;
                                r_oob   <= !in_range;
                                r_state <= ST_QRD;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_QRD: begin
                    r_inj <= '{valid: 1'b1, query: 1'b1, oob: r_oob, slope: '0,
                               icpt: '0, x: r_qx, best: lcmlt_pkg::NO_LINE};
                    r_inj_lvl  <= '0;
                    r_inj_path <= r_qidx;
                    r_state    <= ST_DRAIN;
                end
                ST_SEGL: begin
                    if (r_l < r_r) begin
                        if (r_nl[0]) begin
                            r_inj <= '{valid: 1'b1, query: 1'b0, oob: 1'b0,
                                       slope: r_slope, icpt: r_icpt,
                                       x: '0, best: lcmlt_pkg::NO_LINE};
                            r_inj_lvl  <= r_lvl;
                            r_inj_path <= r_l[LOG_LEAF-1:0];
                            r_nl       <= r_nl + (LOG_LEAF+2)'(1);
                            r_l        <= r_l + r_sz;
                        end
                        r_state <= ST_SEGR;
                    end else begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_SEGR: begin
                    if (r_nr[0]) begin
                        r_inj <= '{valid: 1'b1, query: 1'b0, oob: 1'b0,
                                   slope: r_slope, icpt: r_icpt,
                                   x: '0, best: lcmlt_pkg::NO_LINE};
                        r_inj_lvl  <= r_lvl;
                        r_inj_path <= r_lo[LOG_LEAF-1:0];
                        r_r        <= r_lo;
                    end
                    r_nl    <= r_nl >> 1;
                    r_nr    <= nr_dec >> 1;
                    r_sz    <= r_sz << 1;
                    r_lvl   <= r_lvl - LVW'(1);
                    r_state <= ST_SEGL;
                end
                ST_DRAIN: begin
                    if (!r_inj.valid && !i_chain_busy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_inj      = r_inj;
    assign o_inj_lvl  = r_inj_lvl;
    assign o_inj_path = r_inj_path;
    assign o_clr      = r_state == ST_CLEAR;
    assign o_clr_addr = r_cnt;
    assign o_ld       = r_ld;
    assign o_ld_idx   = r_ld_idx;
    assign o_ld_val   = r_ld_val;

endmodule
